[src/lra_pkg.sv]
// ----------------------------------------------------------------------------
// lra_pkg
// Shared types, widths and constants of the LED ring animator.
// ----------------------------------------------------------------------------
`default_nettype none

package lra_pkg;

  localparam int PIXELS     = 24;
  localparam int IDX_W      = $clog2(PIXELS);
  localparam int CNT_W      = $clog2(PIXELS + 1);
  localparam int WT_W       = $clog2(PIXELS + 2);
  localparam int PIX_IDX_W  = 5;

  localparam int ACTION_W   = 2;
  localparam int MODE_W     = 2;
  localparam int DUR_W      = 24;
  localparam int LEVEL_W    = 16;
  localparam int CHAN_W     = 8;
  localparam int COLOR_W    = 3 * CHAN_W;
  localparam int ELAPSED_W  = 25;

  localparam int BREATH_SCALE = 80;
  localparam int BREATH_WRAP  = 40;
  localparam int GREY_FULL    = 20;
  localparam int GREY_DIM     = 10;
  localparam int BLINK_PERIOD = 100;
  localparam int WIPE_DIV     = 500;

  localparam int NUM_W      = 32;
  localparam int Q_W        = 7;
  localparam int STEP_W     = $clog2(Q_W);
  localparam int BLINK_W    = $clog2(BLINK_PERIOD);
  localparam int WIPE_REM_W = $clog2(WIPE_DIV);

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_SET   = 2'd2
  } action_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_WIPE   = 2'd0,
    MODE_BLINK  = 2'd1,
    MODE_BREATH = 2'd2,
    MODE_VOLUME = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    FK_FILL,
    FK_VOLUME,
    FK_WIPE
  } frame_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SWEEP
  } state_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } div_stat_t;

  function automatic logic [COLOR_W-1:0] grey(input logic [CHAN_W-1:0] v);
    return {v, v, v};
  endfunction

endpackage

`default_nettype wire

[src/lra_if.sv]
// ----------------------------------------------------------------------------
// lra_if
// Valid/ready channels of the LED ring animator: commands in, pixels out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lra_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [lra_pkg::ACTION_W-1:0]  action;
  logic [lra_pkg::MODE_W-1:0]    mode;
  logic [lra_pkg::DUR_W-1:0]     duration_ms;
  logic [lra_pkg::LEVEL_W-1:0]   level;
  logic [lra_pkg::CHAN_W-1:0]    red;
  logic [lra_pkg::CHAN_W-1:0]    green;
  logic [lra_pkg::CHAN_W-1:0]    blue;

  modport source (output valid, action, mode, duration_ms, level, red, green, blue,
                  input ready);
  modport sink (input valid, action, mode, duration_ms, level, red, green, blue,
                output ready);
endinterface

interface lra_pix_if;
  logic                          valid;
  logic                          ready;
  logic [lra_pkg::PIX_IDX_W-1:0] pixel_index;
  logic [lra_pkg::CHAN_W-1:0]    pix_red;
  logic [lra_pkg::CHAN_W-1:0]    pix_green;
  logic [lra_pkg::CHAN_W-1:0]    pix_blue;
  logic                          last_pixel;
  logic                          animation_done;

  modport source (output valid, pixel_index, pix_red, pix_green, pix_blue, last_pixel,
                  animation_done, input ready);
  modport sink (input valid, pixel_index, pix_red, pix_green, pix_blue, last_pixel,
                animation_done, output ready);
endinterface

`default_nettype wire

[src/lra_ram.sv]
// ----------------------------------------------------------------------------
// lra_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                           wr_data,
  input  wire logic                                       rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/lra_div.sv]
// ----------------------------------------------------------------------------
// lra_div
// Restoring divider for the breath level: quotient of 80 * elapsed by the
// duration, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lra_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [lra_pkg::ELAPSED_W-1:0]   elapsed,
  input  wire logic [lra_pkg::DUR_W-1:0]       duration,
  output lra_pkg::div_stat_t                   stat
);

  logic [lra_pkg::NUM_W-1:0]  rem;
  logic [lra_pkg::NUM_W-1:0]  dsh;
  logic [lra_pkg::Q_W-1:0]    quot;
  logic [lra_pkg::STEP_W-1:0] step;
  logic                       busy;
  logic                       done;
  logic                       fits;

  assign fits = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      rem  <= lra_pkg::NUM_W'(elapsed) * lra_pkg::NUM_W'(lra_pkg::BREATH_SCALE);
      dsh  <= lra_pkg::NUM_W'(duration) << (lra_pkg::Q_W - 1);
      quot <= '0;
      step <= lra_pkg::STEP_W'(lra_pkg::Q_W - 1);
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quot <= {quot[lra_pkg::Q_W-2:0], fits};
      dsh  <= dsh >> 1;
      if (step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        step <= step - 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign stat.done = done;
  assign stat.quot = quot;

endmodule

`default_nettype wire

[src/led_ring_animator.sv]
// ----------------------------------------------------------------------------
// led_ring_animator
// Timed animation engine for a ring of RGB pixels with a frame memory.
// ----------------------------------------------------------------------------
// A start beat, and a tick beat while idle, emit nothing. A set beat, and a
// tick beat while an animation runs, repaint the frame memory and emit one
// pixel beat per pixel; the frame is swept through the memory's read and write
// ports at one pixel per cycle while the pixel output is not stalled, and a
// breath tick first runs the bit-serial divider. Commands are taken only
// between frames, while the last pixel of the previous frame may still wait in
// the output register; a stalled pixel output stretches the sweep by the stall.
`default_nettype none

module led_ring_animator (
  input  wire logic clk,
  input  wire logic rst,
  lra_cmd_if.sink   cmd,
  lra_pix_if.source pixel
);

  localparam logic [lra_pkg::ELAPSED_W-1:0] ELAPSED_MAX = '1;

  lra_pkg::state_t                state;
  lra_pkg::state_t                state_next;
  logic                           active;
  lra_pkg::mode_t                 cur_mode;
  logic [lra_pkg::DUR_W-1:0]      cur_duration;
  logic [lra_pkg::LEVEL_W-1:0]    cur_level;
  logic [lra_pkg::COLOR_W-1:0]    base_color;
  logic [lra_pkg::ELAPSED_W-1:0]  elapsed;
  logic [lra_pkg::ELAPSED_W-1:0]  elapsed_next;
  logic [lra_pkg::BLINK_W-1:0]    blink_cnt;
  logic [lra_pkg::BLINK_W-1:0]    blink_cnt_next;
  logic                           blink_phase;
  logic                           blink_phase_next;
  logic [lra_pkg::WIPE_REM_W-1:0] wipe_rem;
  logic [lra_pkg::WIPE_REM_W-1:0] wipe_rem_next;
  logic [lra_pkg::WT_W-1:0]       wipe_t;
  logic [lra_pkg::WT_W-1:0]       wipe_t_next;
  logic [lra_pkg::IDX_W-1:0]      wipe_h;
  logic [lra_pkg::IDX_W-1:0]      wipe_h_next;
  logic [lra_pkg::WIPE_REM_W:0]   wipe_sum;
  logic                           wipe_carry;
  logic [lra_pkg::IDX_W-1:0]      wipe_hm1;
  logic [lra_pkg::IDX_W-1:0]      wipe_hp1;
  logic                           elapsed_inc;
  logic                           ends;

  lra_pkg::frame_kind_t           fkind;
  logic [lra_pkg::COLOR_W-1:0]    fcolor;
  logic                           fdone;

  logic [lra_pkg::CNT_W-1:0]      rd_idx;
  logic                           rd_more;
  logic                           b_valid;
  logic [lra_pkg::IDX_W-1:0]      b_idx;
  logic                           ram_ok;
  logic                           adv;
  logic                           sweep_last;
  logic                           ram_re;
  logic                           ram_we;
  logic [lra_pkg::COLOR_W-1:0]    ram_rd;
  logic [lra_pkg::COLOR_W-1:0]    old_color;
  logic [lra_pkg::COLOR_W-1:0]    new_color;

  logic                           cmd_acc;
  lra_pkg::action_t               cmd_action;
  logic [lra_pkg::COLOR_W-1:0]    cmd_rgb;
  logic                           go_div;
  logic                           go_sweep;
  logic                           div_start;
  lra_pkg::div_stat_t             div_stat;

  function automatic logic [lra_pkg::COLOR_W-1:0] breath_color(
    input logic [lra_pkg::Q_W-1:0] q
  );
    logic [lra_pkg::Q_W-1:0] m;
    begin
      if (q >= lra_pkg::Q_W'(2 * lra_pkg::BREATH_WRAP)) begin
        m = q - lra_pkg::Q_W'(2 * lra_pkg::BREATH_WRAP);
      end else if (q >= lra_pkg::Q_W'(lra_pkg::BREATH_WRAP)) begin
        m = q - lra_pkg::Q_W'(lra_pkg::BREATH_WRAP);
      end else begin
        m = q;
      end
      if (m > lra_pkg::Q_W'(lra_pkg::GREY_FULL)) begin
        m = lra_pkg::Q_W'(lra_pkg::BREATH_WRAP) - m;
      end
      return lra_pkg::grey(lra_pkg::CHAN_W'(m));
    end
  endfunction

  // Command decode and per-millisecond counters.
  assign cmd_acc    = cmd.valid && cmd.ready;
  assign cmd_action = lra_pkg::action_t'(cmd.action);
  assign cmd_rgb    = {cmd.red, cmd.green, cmd.blue};

  assign elapsed_inc  = elapsed != ELAPSED_MAX;
  assign elapsed_next = elapsed + lra_pkg::ELAPSED_W'(elapsed_inc);
  assign ends         = elapsed_next > lra_pkg::ELAPSED_W'(cur_duration);

  always_comb begin
    blink_cnt_next   = blink_cnt;
    blink_phase_next = blink_phase;
    wipe_rem_next    = wipe_rem;
    wipe_t_next      = wipe_t;
    wipe_h_next      = wipe_h;
    wipe_sum         = (lra_pkg::WIPE_REM_W + 1)'(wipe_rem)
                     + (lra_pkg::WIPE_REM_W + 1)'(lra_pkg::PIXELS);
    wipe_carry       = wipe_sum >= (lra_pkg::WIPE_REM_W + 1)'(lra_pkg::WIPE_DIV);
    if (elapsed_inc) begin
      if (blink_cnt == lra_pkg::BLINK_W'(lra_pkg::BLINK_PERIOD - 1)) begin
        blink_cnt_next   = '0;
        blink_phase_next = !blink_phase;
      end else begin
        blink_cnt_next = blink_cnt + 1'b1;
      end
      if (wipe_carry) begin
        wipe_rem_next = lra_pkg::WIPE_REM_W'(
          wipe_sum - (lra_pkg::WIPE_REM_W + 1)'(lra_pkg::WIPE_DIV));
        if (wipe_t != lra_pkg::WT_W'(lra_pkg::PIXELS + 1)) begin
          wipe_t_next = wipe_t + 1'b1;
        end
        if (wipe_h == lra_pkg::IDX_W'(lra_pkg::PIXELS - 1)) begin
          wipe_h_next = '0;
        end else begin
          wipe_h_next = wipe_h + 1'b1;
        end
      end else begin
        wipe_rem_next = lra_pkg::WIPE_REM_W'(wipe_sum);
      end
    end
  end

  assign wipe_hm1 = (wipe_h == '0) ? lra_pkg::IDX_W'(lra_pkg::PIXELS - 1) : wipe_h - 1'b1;
  assign wipe_hp1 = (wipe_h == lra_pkg::IDX_W'(lra_pkg::PIXELS - 1)) ? '0 : wipe_h + 1'b1;

  assign go_div   = cmd_action == lra_pkg::ACT_TICK && active && !ends
                    && cur_mode == lra_pkg::MODE_BREATH;
  assign go_sweep = cmd_action == lra_pkg::ACT_SET
                    || (cmd_action == lra_pkg::ACT_TICK && active && !go_div);
  assign div_start = cmd_acc && go_div;

  // Frame sweep: read pixel i while pixel i-1 is rewritten and emitted.
  assign rd_more    = rd_idx != lra_pkg::CNT_W'(lra_pkg::PIXELS);
  assign adv        = !b_valid || !pixel.valid || pixel.ready;
  assign sweep_last = b_valid && adv && !rd_more;

  // Reads of the memory count as black until the first frame has finished; every
  // frame rewrites all pixels, so from then on every entry holds a written value.
  assign old_color = ram_ok ? ram_rd : '0;

  always_comb begin
    new_color = fcolor;
    case (fkind)
      lra_pkg::FK_FILL: begin
        new_color = fcolor;
      end
      lra_pkg::FK_VOLUME: begin
        new_color = (lra_pkg::LEVEL_W'(b_idx) < cur_level)
                    ? lra_pkg::grey(lra_pkg::CHAN_W'(lra_pkg::GREY_FULL)) : '0;
      end
      lra_pkg::FK_WIPE: begin
        if (b_idx == wipe_h) begin
          new_color = lra_pkg::grey(lra_pkg::CHAN_W'(lra_pkg::GREY_FULL));
        end else if (b_idx == wipe_hm1 || b_idx == wipe_hp1) begin
          new_color = lra_pkg::grey(lra_pkg::CHAN_W'(lra_pkg::GREY_DIM));
        end else if (wipe_t < lra_pkg::WT_W'(lra_pkg::PIXELS + 1)) begin
          new_color = '0;
        end else begin
          new_color = old_color;
        end
      end
      default: begin
        new_color = fcolor;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      lra_pkg::ST_IDLE: begin
        if (cmd_acc && go_div) begin
          state_next = lra_pkg::ST_DIV;
        end else if (cmd_acc && go_sweep) begin
          state_next = lra_pkg::ST_SWEEP;
        end
      end
      lra_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_next = lra_pkg::ST_SWEEP;
        end
      end
      lra_pkg::ST_SWEEP: begin
        if (sweep_last) begin
          state_next = lra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lra_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.ready = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    case (state)
      lra_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
      end
      lra_pkg::ST_SWEEP: begin
        ram_re = adv && rd_more;
        ram_we = adv && b_valid;
      end
      default: begin
        cmd.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lra_pkg::ST_IDLE;
      active       <= 1'b0;
      cur_mode     <= lra_pkg::MODE_WIPE;
      cur_duration <= '0;
      cur_level    <= '0;
      base_color   <= '0;
      elapsed      <= '0;
      blink_cnt    <= '0;
      blink_phase  <= 1'b0;
      wipe_rem     <= '0;
      wipe_t       <= '0;
      wipe_h       <= '0;
      fkind        <= lra_pkg::FK_FILL;
      fdone        <= 1'b0;
      rd_idx       <= '0;
      b_valid      <= 1'b0;
      ram_ok       <= 1'b0;
      pixel.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_acc) begin
        case (cmd_action)
          lra_pkg::ACT_START: begin
            active       <= 1'b1;
            cur_mode     <= lra_pkg::mode_t'(cmd.mode);
            cur_duration <= cmd.duration_ms;
            cur_level    <= cmd.level;
            elapsed      <= '0;
            blink_cnt    <= '0;
            blink_phase  <= 1'b0;
            wipe_rem     <= '0;
            wipe_t       <= '0;
            wipe_h       <= '0;
          end
          lra_pkg::ACT_SET: begin
            base_color <= cmd_rgb;
            fkind      <= lra_pkg::FK_FILL;
            fcolor     <= cmd_rgb;
            fdone      <= 1'b0;
          end
          lra_pkg::ACT_TICK: begin
            if (active) begin
              elapsed     <= elapsed_next;
              blink_cnt   <= blink_cnt_next;
              blink_phase <= blink_phase_next;
              wipe_rem    <= wipe_rem_next;
              wipe_t      <= wipe_t_next;
              wipe_h      <= wipe_h_next;
              fdone       <= ends;
              if (ends) begin
                active <= 1'b0;
                fkind  <= lra_pkg::FK_FILL;
                fcolor <= base_color;
              end else begin
                case (cur_mode)
                  lra_pkg::MODE_VOLUME: fkind <= lra_pkg::FK_VOLUME;
                  lra_pkg::MODE_WIPE:   fkind <= lra_pkg::FK_WIPE;
                  lra_pkg::MODE_BLINK: begin
                    fkind  <= lra_pkg::FK_FILL;
                    fcolor <= blink_phase_next
                              ? '0 : lra_pkg::grey(lra_pkg::CHAN_W'(lra_pkg::GREY_FULL));
                  end
                  default: fkind <= lra_pkg::FK_FILL;
                endcase
              end
            end
          end
          default: begin
          end
        endcase
      end
      if (state == lra_pkg::ST_DIV && div_stat.done) begin
        fcolor <= breath_color(div_stat.quot);
      end
      if (state != lra_pkg::ST_SWEEP) begin
        rd_idx  <= '0;
        b_valid <= 1'b0;
      end else if (adv) begin
        b_valid <= rd_more;
        if (rd_more) begin
          b_idx  <= rd_idx[lra_pkg::IDX_W-1:0];
          rd_idx <= rd_idx + 1'b1;
        end
      end
      if (ram_we && b_idx == lra_pkg::IDX_W'(lra_pkg::PIXELS - 1)) begin
        ram_ok <= 1'b1;
      end
      if (ram_we) begin
        pixel.valid          <= 1'b1;
        pixel.pixel_index    <= lra_pkg::PIX_IDX_W'(b_idx);
        pixel.pix_red        <= new_color[3*lra_pkg::CHAN_W-1:2*lra_pkg::CHAN_W];
        pixel.pix_green      <= new_color[2*lra_pkg::CHAN_W-1:lra_pkg::CHAN_W];
        pixel.pix_blue       <= new_color[lra_pkg::CHAN_W-1:0];
        pixel.last_pixel     <= b_idx == lra_pkg::IDX_W'(lra_pkg::PIXELS - 1);
        pixel.animation_done <= fdone;
      end else if (pixel.ready) begin
        pixel.valid <= 1'b0;
      end
    end
  end

  lra_ram #(
    .WIDTH (lra_pkg::COLOR_W),
    .DEPTH (lra_pkg::PIXELS)
  ) u_frame (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (b_idx),
    .wr_data (new_color),
    .rd_en   (ram_re),
    .rd_addr (rd_idx[lra_pkg::IDX_W-1:0]),
    .rd_data (ram_rd)
  );

  lra_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .elapsed  (elapsed_next),
    .duration (cur_duration),
    .stat     (div_stat)
  );

  a_pipe_in_sweep: assert property (@(posedge clk) disable iff (rst)
    state != lra_pkg::ST_SWEEP |=> !b_valid)
    else $error("pixel stage holds a beat outside a sweep");

  a_pipe_order: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> rd_idx == lra_pkg::CNT_W'(b_idx) + 1'b1)
    else $error("read pointer and pixel stage out of step");

  a_running_bound: assert property (@(posedge clk) disable iff (rst)
    (active && state == lra_pkg::ST_IDLE) |-> elapsed <= lra_pkg::ELAPSED_W'(cur_duration))
    else $error("animation still running past its duration");

  a_wipe_range: assert property (@(posedge clk) disable iff (rst)
    wipe_rem < lra_pkg::WIPE_REM_W'(lra_pkg::WIPE_DIV)
    && wipe_h < lra_pkg::IDX_W'(lra_pkg::PIXELS))
    else $error("wipe position counters out of range");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == lra_pkg::ST_DIV)
    else $error("divider finished outside a breath frame");

endmodule

`default_nettype wire

[test/ring_frame_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_frame_check
// Watches the command and pixel channels of the LED ring animator, keeps its
// own copy of the frame memory and animation state, works out the pixel beats
// that every accepted command beat must produce and compares each accepted
// pixel beat with the oldest one still owed.
// ----------------------------------------------------------------------------

module ring_frame_check
  import lra_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  lra_cmd_if        cmd,
  lra_pix_if        pixel,
  output int        failures,
  output int        backlog
);

  typedef struct packed {
    logic [PIX_IDX_W-1:0] idx;
    logic [COLOR_W-1:0]   rgb;
    logic                 last;
    logic                 done;
  } pixel_beat_t;

  pixel_beat_t          owed_pixels[$];
  logic [COLOR_W-1:0]   ring[PIXELS];
  logic [ELAPSED_W-1:0] elapsed;
  logic                 running;
  mode_t                anim_mode;
  logic [DUR_W-1:0]     anim_len;
  logic [LEVEL_W-1:0]   lit_count;
  logic [COLOR_W-1:0]   base;
  int                   bad = 0;

  function automatic logic [COLOR_W-1:0] shade(input int unsigned v);
    logic [CHAN_W-1:0] c;
    c = CHAN_W'(v);
    return {c, c, c};
  endfunction

  task automatic paint(input logic [COLOR_W-1:0] c);
    foreach (ring[i]) ring[i] = c;
  endtask

  task automatic queue_frame(input logic done);
    pixel_beat_t px;
    for (int i = 0; i < PIXELS; i++) begin
      px.idx  = PIX_IDX_W'(i);
      px.rgb  = ring[i];
      px.last = (i == PIXELS - 1);
      px.done = done;
      owed_pixels.push_back(px);
    end
  endtask

  task automatic draw_frame();
    longint unsigned t;
    int unsigned     b;
    int unsigned     h;
    case (anim_mode)
      MODE_BREATH: begin
        t = (64'(BREATH_SCALE) * 64'(elapsed)) / 64'(anim_len);
        b = int'(t % 64'(BREATH_WRAP));
        if (b > BREATH_WRAP / 2) b = BREATH_WRAP - b;
        paint(shade(b));
      end
      MODE_BLINK: begin
        paint(((elapsed / BLINK_PERIOD) % 2 == 0) ? shade(GREY_FULL) : '0);
      end
      MODE_VOLUME: begin
        foreach (ring[i]) ring[i] = (i < lit_count) ? shade(GREY_FULL) : '0;
      end
      default: begin
        t = (64'(elapsed) * 64'(PIXELS)) / 64'(WIPE_DIV);
        h = int'(t % 64'(PIXELS));
        if (t < 64'(PIXELS + 1)) paint('0);
        ring[(h + PIXELS - 1) % PIXELS] = shade(GREY_DIM);
        ring[h]                         = shade(GREY_FULL);
        ring[(h + 1) % PIXELS]          = shade(GREY_DIM);
      end
    endcase
  endtask

  task automatic take_command();
    case (cmd.action)
      ACT_START: begin
        running   = 1'b1;
        anim_mode = mode_t'(cmd.mode);
        anim_len  = cmd.duration_ms;
        lit_count = cmd.level;
        elapsed   = '0;
      end
      ACT_SET: begin
        base = {cmd.red, cmd.green, cmd.blue};
        paint(base);
        queue_frame(1'b0);
      end
      ACT_TICK: begin
        if (running) begin
          if (elapsed != '1) elapsed = elapsed + 1'b1;
          if (elapsed > anim_len) begin
            paint(base);
            running = 1'b0;
            queue_frame(1'b1);
          end else begin
            draw_frame();
            queue_frame(1'b0);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    pixel_beat_t got;
    pixel_beat_t want;
    if (rst) begin
      owed_pixels.delete();
      paint('0);
      elapsed   = '0;
      running   = 1'b0;
      anim_mode = MODE_WIPE;
      anim_len  = '0;
      lit_count = '0;
      base      = '0;
    end else begin
      if (pixel.valid && pixel.ready) begin
        got = {pixel.pixel_index, pixel.pix_red, pixel.pix_green, pixel.pix_blue,
               pixel.last_pixel, pixel.animation_done};
        if (owed_pixels.size() == 0) begin
          $display("%0t: expected no pixel beat, got idx=%0d rgb=%06x last=%0b done=%0b",
                   $time, got.idx, got.rgb, got.last, got.done);
          bad++;
        end else begin
          want = owed_pixels.pop_front();
          if (got.idx !== want.idx || got.rgb !== want.rgb || got.last !== want.last ||
              got.done !== want.done) begin
            $display("%0t: expected idx=%0d rgb=%06x last=%0b done=%0b, got idx=%0d rgb=%06x last=%0b done=%0b",
                     $time, want.idx, want.rgb, want.last, want.done,
                     got.idx, got.rgb, got.last, got.done);
            bad++;
          end
        end
      end
      if (cmd.valid && cmd.ready) take_command();
    end
    failures <= bad;
    backlog  <= owed_pixels.size();
  end

endmodule

[test/tb_led_ring_animator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_ring_animator
// Drives tick, start and set beats into the LED ring animator with random
// gaps and a random stall on the pixel side, including one long stall that
// backs the block up; a directed opening covers each mode and corner case,
// random animation sequences and one wipe run that opens with back-to-back ticks follow,
// and the pixel checker decides the verdict.
// ----------------------------------------------------------------------------

module tb_led_ring_animator;
  import lra_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_BEATS     = 180;
  localparam int WIPE_RUN_TICKS   = 40;
  localparam int LONG_HOLD        = 600;
  localparam int DRAIN_CYCLES     = 40;
  localparam int CYCLE_LIMIT      = 4_000_000;

  logic        clk;
  logic        rst;
  int          failures;
  int          backlog;
  bit          calm = 1'b0;
  bit          hold_ask = 1'b0;
  int unsigned cycle_count = 0;

  lra_cmd_if cmd();
  lra_pix_if pixel();

  led_ring_animator dut (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .pixel (pixel)
  );

  ring_frame_check frame_check (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .pixel    (pixel),
    .failures (failures),
    .backlog  (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("led_ring_animator test failed");
      $finish;
    end
  end

  function automatic int idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  task automatic send_beat(input logic [ACTION_W-1:0] act, input logic [MODE_W-1:0] md,
                           input logic [DUR_W-1:0] dur, input logic [LEVEL_W-1:0] lvl,
                           input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                           input logic [CHAN_W-1:0] b);
    int gap;
    gap = (calm || $urandom_range(0, 2) == 0) ? 0 : idle_span();
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid       <= 1'b1;
    cmd.action      <= act;
    cmd.mode        <= md;
    cmd.duration_ms <= dur;
    cmd.level       <= lvl;
    cmd.red         <= r;
    cmd.green       <= g;
    cmd.blue        <= b;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  task automatic tick_beats(input int n);
    for (int k = 0; k < n; k++) begin
      send_beat(ACT_TICK, MODE_W'($urandom), DUR_W'($urandom), LEVEL_W'($urandom),
                CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
    end
  endtask

  task automatic start_anim(input logic [MODE_W-1:0] md, input logic [DUR_W-1:0] dur,
                            input logic [LEVEL_W-1:0] lvl);
    send_beat(ACT_START, md, dur, lvl, CHAN_W'($urandom), CHAN_W'($urandom),
              CHAN_W'($urandom));
  endtask

  task automatic paint_base(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] b);
    send_beat(ACT_SET, MODE_W'($urandom), DUR_W'($urandom), LEVEL_W'($urandom), r, g, b);
  endtask

  initial begin : pixel_sink
    int span;
    forever begin
      if (hold_ask) begin
        hold_ask = 1'b0;
        pixel.ready <= 1'b0;
        span = LONG_HOLD;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        pixel.ready <= 1'b1;
        span = calm ? 1 : $urandom_range(1, 24);
      end else begin
        pixel.ready <= 1'b0;
        span = idle_span();
      end
      repeat (span) @(posedge clk);
    end
  end

  initial begin : stimulus
    int                 counted;
    int                 pick;
    int                 n;
    int                 sel;
    logic [MODE_W-1:0]  md;
    logic [DUR_W-1:0]   dur;
    logic [LEVEL_W-1:0] lvl;

    rst             <= 1'b1;
    cmd.valid       <= 1'b0;
    cmd.action      <= ACT_TICK;
    cmd.mode        <= MODE_WIPE;
    cmd.duration_ms <= '0;
    cmd.level       <= '0;
    cmd.red         <= '0;
    cmd.green       <= '0;
    cmd.blue        <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    tick_beats(1);
    send_beat(ACT_UNUSED, MODE_VOLUME, '1, '1, '1, '1, '1);
    paint_base(8'hFF, 8'h00, 8'hA5);
    paint_base(8'h00, 8'hFF, 8'h5A);
    start_anim(MODE_WIPE, '0, '0);
    tick_beats(1);
    start_anim(MODE_BREATH, 24'd1, '1);
    tick_beats(2);
    start_anim(MODE_BLINK, '1, '0);
    tick_beats(2);
    start_anim(MODE_VOLUME, 24'd10, '1);
    tick_beats(1);
    start_anim(MODE_VOLUME, 24'd10, LEVEL_W'(PIXELS - 1));
    tick_beats(1);
    start_anim(MODE_WIPE, 24'd1000, 16'd3);
    tick_beats(1);
    start_anim(MODE_BREATH, 24'd3, '0);
    tick_beats(4);
    paint_base(8'hFF, 8'hFF, 8'hFF);
    tick_beats(1);

    hold_ask = 1'b1;
    counted = 0;
    while (counted < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        md  = MODE_W'($urandom);
        sel = $urandom_range(0, 9);
        if (sel < 3) dur = DUR_W'($urandom_range(0, 4));
        else if (sel < 7) dur = DUR_W'($urandom_range(5, 150));
        else if (sel < 9) dur = DUR_W'($urandom_range(151, 3000));
        else dur = DUR_W'($urandom);
        lvl = ($urandom_range(0, 1) == 0) ? LEVEL_W'($urandom_range(0, PIXELS + 2))
                                          : LEVEL_W'($urandom);
        start_anim(md, dur, lvl);
        n = ($urandom_range(0, 3) == 0) ? ((dur < 128) ? int'(dur) + 2 : 130)
                                        : $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 19) == 0)
            paint_base(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
          else
            tick_beats(1);
        end
        counted += n + 1;
      end else if (pick < 85) begin
        paint_base(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
        counted++;
      end else if (pick < 93) begin
        send_beat(ACT_UNUSED, MODE_W'($urandom), DUR_W'($urandom), LEVEL_W'($urandom),
                  CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
        counted++;
      end else begin
        tick_beats(1);
        counted++;
      end
    end

    calm = 1'b1;
    start_anim(MODE_WIPE, DUR_W'(WIPE_RUN_TICKS), LEVEL_W'($urandom));
    tick_beats(WIPE_RUN_TICKS / 2);
    calm = 1'b0;
    tick_beats(WIPE_RUN_TICKS - WIPE_RUN_TICKS / 2 + 2);

    cmd.valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("led_ring_animator test passed");
    end else begin
      $display("led_ring_animator test failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/lra_pkg.sv
src/lra_if.sv
src/lra_ram.sv
src/lra_div.sv
src/led_ring_animator.sv
test/ring_frame_check.sv
test/tb_led_ring_animator.sv
